/* src/pkdlp_pkg.sv */
`timescale 1ns / 1ps
// Package for the priority key debouncer with long-press detection.
// Holds the shared types and constants; no dependencies.
package pkdlp_pkg;

  localparam int unsigned NumKeys    = 6;
  localparam int unsigned KeyIdxW    = 3;
  localparam int unsigned EventW     = 3;
  localparam int unsigned DebounceW  = 8;
  localparam int unsigned ElapsedW   = 16;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [KeyIdxW-1:0]  LastKey    = 3'd5;
  localparam logic [EventW-1:0]   LongCode   = 3'd6;
  localparam logic [ElapsedW-1:0] ElapsedMax = 16'hFFFF;

  // Configuration register indexes.
  localparam logic CfgDebounce  = 1'b0;
  localparam logic CfgLongPress = 1'b1;

  localparam logic [DebounceW-1:0] DebounceReset  = 8'd5;
  localparam logic [ElapsedW-1:0]  LongPressReset = 16'd1000;

  typedef enum logic [2:0] {
    PhaseIdle     = 3'b001,
    PhaseDebounce = 3'b010,
    PhaseWait     = 3'b100
  } phase_e;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_ticks;
    logic [ElapsedW-1:0]  long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [EventW-1:0] code;
  } event_t;

endpackage

/* src/pkdlp_fsm.sv */
`timescale 1ns / 1ps
// Key tracking state machine: priority select, elapsed counter, debounce
// check and release detection. Depends on pkdlp_pkg.
module pkdlp_fsm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic [pkdlp_pkg::NumKeys-1:0]       keys_i,
  input  pkdlp_pkg::cfg_t                     cfg_i,
  output pkdlp_pkg::event_t                   evt_o
);
  import pkdlp_pkg::*;

  phase_e              phase_q, phase_d;
  logic [KeyIdxW-1:0]  chosen_q, chosen_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [ElapsedW-1:0] elapsed_inc;
  logic                chosen_down;
  logic                any_down;
  logic [KeyIdxW-1:0]  first_key;

  assign elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;
  assign chosen_down = keys_i[chosen_q];
  assign any_down    = |keys_i;

  // Lowest-numbered pressed key wins.
  always_comb begin
    first_key = '0;
    for (int i = NumKeys - 1; i >= 0; i--) begin
      if (keys_i[i]) begin
        first_key = KeyIdxW'(i);
      end
    end
  end

  always_comb begin
    phase_d   = phase_q;
    chosen_d  = chosen_q;
    elapsed_d = elapsed_q;
    evt_o     = '0;
    if (step_i) begin
      unique case (phase_q)
        PhaseDebounce: begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= {{(ElapsedW-DebounceW){1'b0}}, cfg_i.debounce_ticks}) begin
            phase_d = chosen_down ? PhaseWait : PhaseIdle;
          end
        end
        PhaseWait: begin
          elapsed_d = elapsed_inc;
          if (!chosen_down) begin
            phase_d    = PhaseIdle;
            evt_o.valid = 1'b1;
            if (chosen_q == LastKey && elapsed_inc > cfg_i.long_press_ticks) begin
              evt_o.code = LongCode;
            end else begin
              evt_o.code = chosen_q;
            end
          end
        end
        default: begin
          // Idle, and any stray encoding is treated as idle.
          phase_d = PhaseIdle;
          if (any_down) begin
            chosen_d  = first_key;
            elapsed_d = '0;
            phase_d   = PhaseDebounce;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhaseIdle;
      chosen_q  <= '0;
      elapsed_q <= '0;
    end else begin
      phase_q   <= phase_d;
      chosen_q  <= chosen_d;
      elapsed_q <= elapsed_d;
    end
  end

`ifndef SYNTHESIS
  a_event_only_from_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.valid |-> (phase_q == PhaseWait))
    else $error("key event raised outside the wait phase");

  a_press_starts_debounce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PhaseIdle && any_down)
      |=> (phase_q == PhaseDebounce && elapsed_q == '0))
    else $error("new press did not start debouncing with a cleared counter");

  a_long_only_last_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_o.valid && evt_o.code == LongCode) |-> (chosen_q == LastKey))
    else $error("long press reported for a key other than the last one");

  a_hold_without_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(elapsed_q) && $stable(chosen_q) && $stable(phase_q)))
    else $error("tracking state changed without a tick");
`endif

endmodule

/* src/priority_key_debounce_long_press.sv */
`timescale 1ns / 1ps
// Top level of the six-key priority debouncer with long-press detection.
// Holds the configuration, input and result registers; depends on
// pkdlp_pkg and pkdlp_fsm.
//
// Usage: one transaction on the input channel carries one tick's key flags
// (bit 0 highest priority). A result transaction carries a key event:
// 0 to 4 for keys 0 to 4, 5 for a short press of key 5, 6 for a long press
// of key 5. Most ticks produce no result.
// A tick accepted into the input register is evaluated when the tracker
// advances, and its event (if any) is registered in the result register
// and driven on key_event_o. Throughput: one tick per cycle, set by the
// single evaluation stage between the input and result registers, which
// advances whenever the result register is empty or being drained.
// Stall: while a result waits for out_ready_i, the input register still
// takes one more tick; further ticks are held off until the result leaves.
// Reset: debounce_ticks is 5, long_press_ticks is 1000, the tracker is idle
// and both registers are empty. Configuration is written through cfg_we_i,
// cfg_idx_i (0 debounce, 1 long press) and cfg_wdata_i; the user must do
// this only while idle, as the block itself does not enforce it.
module priority_key_debounce_long_press (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [pkdlp_pkg::NumKeys-1:0]        keys_pressed_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [pkdlp_pkg::EventW-1:0]         key_event_o,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [pkdlp_pkg::CfgDataW-1:0]       cfg_wdata_i
);
  import pkdlp_pkg::*;

  cfg_t               cfg_q;
  logic               in_valid_q;
  logic [NumKeys-1:0] keys_q;
  logic               out_valid_q;
  logic [EventW-1:0]  out_code_q;
  logic               advance;
  event_t             evt;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign key_event_o = out_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= DebounceReset;
      cfg_q.long_press_ticks <= LongPressReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDebounce:  cfg_q.debounce_ticks   <= cfg_wdata_i[DebounceW-1:0];
        CfgLongPress: cfg_q.long_press_ticks <= cfg_wdata_i[ElapsedW-1:0];
        default:      cfg_q                  <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      keys_q <= keys_pressed_i;
    end
  end

  pkdlp_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .keys_i (keys_q),
    .cfg_i  (cfg_q),
    .evt_o  (evt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= evt.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && evt.valid) begin
      out_code_q <= evt.code;
    end
  end

endmodule
